FILE: rtl/rms_vector_distance_top_defines.svh
// Assertion macros shared by the checker of the RMS vector distance block.
// No dependencies; included by files that hold concurrent assertions.
`ifndef RMS_VECTOR_DISTANCE_TOP_DEFINES_SVH
`define RMS_VECTOR_DISTANCE_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RVD_ASSERT_SAME(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("rms_vector_distance assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define RVD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("rms_vector_distance assertion failed");

`endif

FILE: rtl/rvd_pkg.sv
// Package of the RMS vector distance block: widths, reset values and shared types.
// No dependencies; imported by every module of the block.
`default_nettype none

package rvd_pkg;

	// Largest vector length; longer settings are clamped to it.
	localparam int MAX_DIM = 4096;

	// Field and register widths.
	localparam int DATA_W        = 16;
	localparam int VEC_LEN_W     = 13;
	localparam int VEC_LEN_RESET = 128;

	// Effective length and element count both hold values up to MAX_DIM.
	localparam int LEN_W = $clog2(MAX_DIM + 1);

	// Root width and the (even) width of the running sum of squares.
	localparam int SQ_W  = (33 + $clog2(MAX_DIM)) / 2;
	localparam int SUM_W = 2 * SQ_W;

	// Width of the shared compare-subtract unit (root remainder bound plus margin).
	localparam int CS_W = SQ_W + 4;

	// Step counter covers the longer of the divide and root loops.
	localparam int ITER_W = $clog2(SUM_W);

	// Result of the shared compare-subtract unit.
	typedef struct packed {
		logic            ge;
		logic [CS_W-1:0] diff;
	} cs_res_t;

endpackage

`default_nettype wire

FILE: rtl/rvd_cmpsub.sv
// Shared compare-subtract unit used by the divider and the square root steps.
// Depends on rvd_pkg for its width and result type.
`default_nettype none

module rvd_cmpsub (
	input  wire logic [rvd_pkg::CS_W-1:0] lhs,
	input  wire logic [rvd_pkg::CS_W-1:0] rhs,
	output rvd_pkg::cs_res_t              res
);
	import rvd_pkg::*;

	logic [CS_W:0] wide_diff;

	// One subtractor gives both the difference and the compare from its borrow.
	always_comb begin
		wide_diff = {1'b0, lhs} - {1'b0, rhs};
		res.ge    = ~wide_diff[CS_W];
		res.diff  = wide_diff[CS_W-1:0];
	end

endmodule

`default_nettype wire

FILE: rtl/rvd_seq.sv
// Sequencer and datapath: squares each difference, accumulates, then divides
// and takes the root one bit a cycle. Depends on rvd_pkg and rvd_cmpsub.
`default_nettype none

module rvd_seq (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [rvd_pkg::DATA_W-1:0]  coord_a,
	input  wire logic [rvd_pkg::DATA_W-1:0]  coord_b,
	input  wire logic [rvd_pkg::LEN_W-1:0]   eff_len,
	output logic                             res_valid,
	input  wire logic                        res_ready,
	output logic [rvd_pkg::DATA_W-1:0]       res_data
);
	import rvd_pkg::*;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_MUL  = 3'd1;
	localparam logic [2:0] ST_ACC  = 3'd2;
	localparam logic [2:0] ST_DIV  = 3'd3;
	localparam logic [2:0] ST_SQRT = 3'd4;
	localparam logic [2:0] ST_HOLD = 3'd5;

	logic [2:0]          state_q;
	logic [SUM_W-1:0]    sum_q;
	logic [LEN_W-1:0]    count_q;
	logic [ITER_W-1:0]   iter_q;
	logic [DATA_W-1:0]   absdiff_q;
	logic [2*DATA_W-1:0] prod_q;
	logic [CS_W-1:0]     rem_q;
	logic [SQ_W-1:0]     root_q;

	logic [DATA_W:0]     diff;
	logic [DATA_W-1:0]   absdiff;
	logic [SUM_W-1:0]    sum_next;
	logic [LEN_W-1:0]    count_next;
	logic                vec_done;
	logic [CS_W-1:0]     cs_lhs;
	logic [CS_W-1:0]     cs_rhs;
	cs_res_t             cs_res;

	assign in_ready  = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_HOLD);
	assign res_data  = root_q[DATA_W-1:0];

	// Absolute difference of the two signed coordinates; it always fits 16 bits.
	always_comb begin
		diff    = {coord_a[DATA_W-1], coord_a} - {coord_b[DATA_W-1], coord_b};
		absdiff = diff[DATA_W] ? DATA_W'(-diff) : diff[DATA_W-1:0];
	end

	// Running sum and element count as they stand after this item.
	always_comb begin
		sum_next   = sum_q + SUM_W'(prod_q);
		count_next = count_q + LEN_W'(1);
		vec_done   = (count_next >= eff_len);
	end

	// Operand selection for the shared unit: divide step or root step.
	always_comb begin
		if (state_q == ST_SQRT) begin
			cs_lhs = {rem_q[CS_W-3:0], sum_q[SUM_W-1 -: 2]};
			cs_rhs = CS_W'({root_q, 2'b01});
		end else begin
			cs_lhs = CS_W'({rem_q[LEN_W-1:0], sum_q[SUM_W-1]});
			cs_rhs = CS_W'(eff_len);
		end
	end

	rvd_cmpsub u_cmpsub (
		.lhs (cs_lhs),
		.rhs (cs_rhs),
		.res (cs_res)
	);

	// Control state, running sum and element count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			sum_q   <= '0;
			count_q <= '0;
			iter_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					state_q <= ST_ACC;
				end
				ST_ACC: begin
					sum_q <= sum_next;
					if (vec_done) begin
						count_q <= '0;
						iter_q  <= ITER_W'(SUM_W - 1);
						state_q <= ST_DIV;
					end else begin
						count_q <= count_next;
						state_q <= ST_IDLE;
					end
				end
				ST_DIV: begin
					// Quotient bits shift in where the dividend bits leave.
					sum_q <= {sum_q[SUM_W-2:0], cs_res.ge};
					if (iter_q == '0) begin
						iter_q  <= ITER_W'(SQ_W - 1);
						state_q <= ST_SQRT;
					end else begin
						iter_q <= iter_q - ITER_W'(1);
					end
				end
				ST_SQRT: begin
					// Two radicand bits are consumed each step.
					sum_q <= {sum_q[SUM_W-3:0], 2'b00};
					if (iter_q == '0) begin
						state_q <= ST_HOLD;
					end else begin
						iter_q <= iter_q - ITER_W'(1);
					end
				end
				ST_HOLD: begin
					if (res_ready) begin
						sum_q   <= '0;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Datapath registers: difference, square, remainder and root.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				absdiff_q <= absdiff;
			end
			ST_MUL: begin
				prod_q <= absdiff_q * absdiff_q;
			end
			ST_ACC: begin
				rem_q <= '0;
			end
			ST_DIV: begin
				if (iter_q == '0) begin
					rem_q  <= '0;
					root_q <= '0;
				end else if (cs_res.ge) begin
					rem_q <= cs_res.diff;
				end else begin
					rem_q <= cs_lhs;
				end
			end
			ST_SQRT: begin
				if (cs_res.ge) begin
					rem_q  <= cs_res.diff;
					root_q <= {root_q[SQ_W-2:0], 1'b1};
				end else begin
					rem_q  <= cs_lhs;
					root_q <= {root_q[SQ_W-2:0], 1'b0};
				end
			end
			default: begin
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: rtl/rms_vector_distance_top.sv
// RMS vector distance, top level: length register, output register, sequencer.
// Depends on rvd_pkg and rvd_seq.
//
// Each input item on the s_ group carries one coordinate pair (signed Q8.8).
// The block squares the difference and adds it to a running sum. When the
// pair that completes a vector arrives (vector length set by cfg_wdata when
// cfg_wen is high; 0 acts as 1, values above the maximum are clamped), the
// sum is divided by the length and the floor square root goes out on the m_
// group as one unsigned Q8.8 item.
// Sequencing: each item passes the MUL and ACC states, and no new item is
// taken until the block is back in IDLE. The completing item also runs 44
// divide steps and 22 root steps; both loops run on one shared
// compare-subtract unit that yields one quotient or root bit a cycle.
// Reset sets the length to 128, clears the sum and count, drops any result.
// A stalled receiver keeps its result in the output register while the next
// vector is accumulated; a further result waits in the sequencer, and input
// is held off until the output register frees up.
`default_nettype none

module rms_vector_distance_top (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	// s_tdata fields from bit 0: coord_a[15:0], coord_b[15:0].
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [2*rvd_pkg::DATA_W-1:0]   s_tdata,
	// m_tdata fields from bit 0: rms_dist[15:0].
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic [rvd_pkg::DATA_W-1:0]          m_tdata,
	input  wire logic                           cfg_wen,
	input  wire logic [rvd_pkg::VEC_LEN_W-1:0]  cfg_wdata
);
	import rvd_pkg::*;

	logic [VEC_LEN_W-1:0] vec_len_q;
	logic [LEN_W-1:0]     eff_len;
	logic                 res_valid;
	logic                 res_ready;
	logic [DATA_W-1:0]    res_data;
	logic                 m_tvalid_q;
	logic [DATA_W-1:0]    m_tdata_q;

	// Vector length register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vec_len_q <= VEC_LEN_W'(VEC_LEN_RESET);
		end else if (cfg_wen) begin
			vec_len_q <= cfg_wdata;
		end
	end

	// Effective length: zero counts as one, long settings are clamped.
	always_comb begin
		priority if (vec_len_q == '0) begin
			eff_len = LEN_W'(1);
		end else if (32'(vec_len_q) > 32'(MAX_DIM)) begin
			eff_len = LEN_W'(MAX_DIM);
		end else begin
			eff_len = LEN_W'(vec_len_q);
		end
	end

	rvd_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.coord_a   (s_tdata[DATA_W-1:0]),
		.coord_b   (s_tdata[2*DATA_W-1:DATA_W]),
		.eff_len   (eff_len),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_data  (res_data)
	);

	// Output register: takes a result whenever it is empty or being drained.
	assign res_ready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (res_ready) begin
			m_tvalid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			m_tdata_q <= res_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule

`default_nettype wire

FILE: rtl/rvd_checker.sv
// Port-level checker of the RMS vector distance block and its bind to the top.
// Depends on rvd_pkg and the assertion macros of rms_vector_distance_top_defines.svh.
`default_nettype none
`include "rms_vector_distance_top_defines.svh"

module rvd_checker (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          s_tvalid,
	input  wire logic                          s_tready,
	input  wire logic                          m_tvalid,
	input  wire logic                          m_tready,
	input  wire logic [rvd_pkg::DATA_W-1:0]    m_tdata
);
	import rvd_pkg::*;

	// A result that is not taken stays valid and unchanged.
	`RVD_ASSERT_NEXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

	// The sequencer is busy in the cycle after each accepted item.
	`RVD_ASSERT_NEXT(a_busy_after_item, clk, arst_n, s_tvalid && s_tready, !s_tready)

	// No result can be produced in the cycle right after an item is accepted.
	`RVD_ASSERT_NEXT(a_no_early_result, clk, arst_n, s_tvalid && s_tready, !$rose(m_tvalid))

endmodule

bind rms_vector_distance_top rvd_checker u_rvd_checker (.*);

`default_nettype wire

FILE: tb/tb.sv
// Self-checking testbench of the RMS vector distance block.
// Depends on rvd_pkg and rms_vector_distance_top; drives both streams and the length register.
`default_nettype none

module tb;
	import rvd_pkg::*;

	localparam int DRAIN_CYCLES = 80;
	localparam int HOLD_CYCLES  = 400;
	localparam int RANDOM_ITEMS = 330;
	localparam int BIG_ITEMS    = 16;

	// One row of the directed table: optional length write, a pair, optional typed distance.
	typedef struct packed {
		bit                   wr;
		bit [VEC_LEN_W-1:0]   len;
		bit [DATA_W-1:0]      a;
		bit [DATA_W-1:0]      b;
		bit                   has_exp;
		bit [DATA_W-1:0]      want_rms;
	} dir_row_t;

	localparam int DIR_ROWS = 17;
	localparam dir_row_t DIR_TAB [0:DIR_ROWS-1] = '{
		'{1'b0, 13'd0,    16'h0100, 16'h0000, 1'b0, 16'h0000},
		'{1'b1, 13'd1,    16'h0000, 16'h0000, 1'b1, 16'h0100},
		'{1'b0, 13'd0,    16'h7FFF, 16'h8000, 1'b1, 16'hFFFF},
		'{1'b0, 13'd0,    16'h8000, 16'h7FFF, 1'b1, 16'hFFFF},
		'{1'b0, 13'd0,    16'h0000, 16'h0000, 1'b1, 16'h0000},
		'{1'b0, 13'd0,    16'hFFFF, 16'h0000, 1'b1, 16'h0001},
		'{1'b1, 13'd0,    16'h0003, 16'hFFFF, 1'b1, 16'h0004},
		'{1'b0, 13'd0,    16'h8000, 16'h8000, 1'b1, 16'h0000},
		'{1'b0, 13'd0,    16'h7FFF, 16'h7FFF, 1'b1, 16'h0000},
		'{1'b1, 13'd2,    16'h0100, 16'h0000, 1'b0, 16'h0000},
		'{1'b0, 13'd0,    16'h0300, 16'h0000, 1'b0, 16'h0000},
		'{1'b1, 13'd4,    16'h0200, 16'h0000, 1'b0, 16'h0000},
		'{1'b0, 13'd0,    16'h0000, 16'h0200, 1'b0, 16'h0000},
		'{1'b1, 13'd2,    16'h0200, 16'h0200, 1'b1, 16'h0200},
		'{1'b1, 13'd3,    16'h1234, 16'hFEDC, 1'b0, 16'h0000},
		'{1'b0, 13'd0,    16'h5555, 16'hAAAA, 1'b0, 16'h0000},
		'{1'b0, 13'd0,    16'hAAAA, 16'h5555, 1'b0, 16'h0000}
	};

	logic                       clk;
	logic                       arst_n;
	logic                       s_tvalid;
	logic                       s_tready;
	// s_tdata fields from bit 0: coord_a[15:0], coord_b[15:0].
	logic [2*DATA_W-1:0]        s_tdata;
	logic                       m_tvalid;
	logic                       m_tready;
	// m_tdata fields from bit 0: rms_dist[15:0].
	logic [DATA_W-1:0]          m_tdata;
	logic                       cfg_wen;
	logic [VEC_LEN_W-1:0]       cfg_wdata;

	// Predictor state: length register, running sum and pair count.
	logic [VEC_LEN_W-1:0]       len_reg;
	logic [SUM_W-1:0]           acc_sum;
	int unsigned                acc_count;

	logic [DATA_W-1:0]          want_dist_q [$];
	int unsigned                errors;
	int unsigned                n_pairs;
	int unsigned                n_dists;
	int unsigned                n_len_writes;
	bit                         calm;
	bit                         hold_off_req;

	rms_vector_distance_top uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_wen   (cfg_wen),
		.cfg_wdata (cfg_wdata)
	);

	// Clock with a period of 20.
	initial clk = 1'b0;
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Accumulate one pair; returns 1 with the distance when the pair completes a vector.
	function automatic bit rms_predict(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			output logic [DATA_W-1:0] rms_out);
		logic signed [DATA_W:0] diff;
		logic [DATA_W:0]        mag;
		logic [SUM_W-1:0]       mag_w;
		logic [SUM_W-1:0]       mean;
		logic [SUM_W-1:0]       trial_w;
		logic [SQ_W-1:0]        root;
		logic [SQ_W-1:0]        trial;
		int unsigned            n;
		diff = {a[DATA_W-1], a} - {b[DATA_W-1], b};
		mag = diff[DATA_W] ? (~diff + 1'b1) : diff;
		mag_w = SUM_W'(mag);
		n = (len_reg == 0) ? 1 : ((len_reg > MAX_DIM) ? MAX_DIM : len_reg);
		acc_sum = acc_sum + mag_w * mag_w;
		acc_count++;
		rms_out = '0;
		if (acc_count < n)
			return 1'b0;
		mean = acc_sum / n;
		// Floor square root, one bit at a time from the top.
		root = '0;
		for (int i = SQ_W - 1; i >= 0; i--) begin
			trial = root | (SQ_W'(1) << i);
			trial_w = SUM_W'(trial);
			if (trial_w * trial_w <= mean)
				root = trial;
		end
		rms_out = root[DATA_W-1:0];
		acc_sum = '0;
		acc_count = 0;
		return 1'b1;
	endfunction

	// Coordinate with a bias toward the extremes and small magnitudes.
	function automatic logic [DATA_W-1:0] pick_coord();
		logic [DATA_W-1:0] v;
		case ($urandom_range(0, 7))
			0: v = 16'h7FFF;
			1: v = 16'h8000;
			2: v = 16'h0000;
			3: v = 16'($urandom_range(0, 16'h03FF)) - 16'h0200;
			default: v = 16'($urandom);
		endcase
		return v;
	endfunction

	// Send one pair; a typed distance, if given, replaces the predicted one.
	task automatic send_pair(input logic [DATA_W-1:0] a, input logic [DATA_W-1:0] b,
			input bit has_exp, input logic [DATA_W-1:0] typed);
		int unsigned       w;
		logic [DATA_W-1:0] pred_rms;
		w = calm ? 0 : $urandom_range(0, 14);
		if (w > 0) begin
			s_tvalid <= 1'b0;
			repeat (w) @(negedge clk);
		end
		s_tdata <= {b, a};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!(s_tvalid && s_tready));
		n_pairs++;
		if (rms_predict(a, b, pred_rms))
			want_dist_q.push_back(has_exp ? typed : pred_rms);
		@(negedge clk);
	endtask

	// Write the length once the block has gone quiet.
	task automatic write_len(input logic [VEC_LEN_W-1:0] v);
		s_tvalid <= 1'b0;
		while (want_dist_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		cfg_wdata <= v;
		cfg_wen <= 1'b1;
		@(negedge clk);
		cfg_wen <= 1'b0;
		len_reg = v;
		n_len_writes++;
	endtask

	// Receiver: random ready gaps, and one long hold-off on request.
	initial begin : rx_side
		int unsigned w;
		m_tready = 1'b0;
		wait (arst_n);
		@(negedge clk);
		forever begin
			w = calm ? 0 : $urandom_range(0, 14);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				w = HOLD_CYCLES;
			end
			if (w > 0) begin
				m_tready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready));
			@(negedge clk);
		end
	end

	// Compare every accepted distance with the oldest expectation.
	always @(posedge clk) begin : dist_check
		logic [DATA_W-1:0] want;
		if (arst_n && m_tvalid && m_tready) begin
			n_dists++;
			if (want_dist_q.size() == 0) begin
				$display("%0t: distance %h with none expected", $time, m_tdata);
				errors++;
			end else begin
				want = want_dist_q.pop_front();
				if (m_tdata !== want) begin
					$display("%0t: distance expected %h, actual %h", $time, want, m_tdata);
					errors++;
				end
			end
		end
	end

	// Run limit.
	initial begin
		#40_000_000;
		$display("[rms_vector_distance_top] ERROR");
		$finish;
	end

	// Stimulus.
	initial begin : stim
		int unsigned       left;
		int unsigned       n_eff;
		logic [DATA_W-1:0] a;
		logic [DATA_W-1:0] b;
		errors = 0;
		n_pairs = 0;
		n_dists = 0;
		n_len_writes = 0;
		calm = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wen = 1'b0;
		cfg_wdata = '0;
		len_reg = VEC_LEN_RESET;
		acc_sum = '0;
		acc_count = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed rows: reset length, extremes, zero length, shrinking mid-vector.
		for (int r = 0; r < DIR_ROWS; r++) begin
			if (DIR_TAB[r].wr)
				write_len(DIR_TAB[r].len);
			send_pair(DIR_TAB[r].a, DIR_TAB[r].b, DIR_TAB[r].has_exp, DIR_TAB[r].want_rms);
		end

		// Longest settings: the exact maximum with random data, then a clamped
		// length with the largest difference throughout; the one vector is left
		// open across both settings and closed later by a shorter length.
		write_len(VEC_LEN_W'(MAX_DIM));
		for (int i = 0; i < BIG_ITEMS; i++)
			send_pair(pick_coord(), pick_coord(), 1'b0, '0);
		write_len({VEC_LEN_W{1'b1}});
		calm = 1'b1;
		for (int i = 0; i < BIG_ITEMS; i++) begin
			if (i[0])
				send_pair(16'h8000, 16'h7FFF, 1'b0, '0);
			else
				send_pair(16'h7FFF, 16'h8000, 1'b0, '0);
		end

		// Back pressure: one result per pair while the receiver holds off.
		write_len(13'd1);
		hold_off_req = 1'b1;
		for (int i = 0; i < 24; i++)
			send_pair(pick_coord(), pick_coord(), 1'b0, '0);

		// Random phases: mostly short vectors, some left unfinished across a length change.
		left = RANDOM_ITEMS;
		while (left > 0) begin
			case ($urandom_range(0, 9))
				0: write_len(13'd0);
				1: write_len(13'd1);
				2, 3, 4, 5, 6: write_len(13'($urandom_range(2, 8)));
				7, 8: write_len(13'($urandom_range(9, 40)));
				default: write_len(13'($urandom_range(41, 100)));
			endcase
			calm = ($urandom_range(0, 3) == 0);
			n_eff = (len_reg == 0) ? 1 : len_reg;
			n_eff = n_eff * $urandom_range(1, 3) +
				(($urandom_range(0, 2) == 0) ? $urandom_range(1, n_eff) : 0);
			for (int i = 0; i < n_eff && left > 0; i++) begin
				a = pick_coord();
				b = pick_coord();
				send_pair(a, b, 1'b0, '0);
				left--;
			end
		end

		// Drain and report.
		s_tvalid <= 1'b0;
		while (want_dist_q.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Sent %0d coordinate pairs under %0d length settings; %0d distances compared.",
			n_pairs, n_len_writes, n_dists);
		if (errors == 0)
			$display("[rms_vector_distance_top] OK");
		else
			$display("[rms_vector_distance_top] ERROR");
		$finish;
	end

endmodule

`default_nettype wire
